### src/wq_pkg.sv
// Shared types and codes for the wait queue controller and datapath.
package wq_pkg;

    // Default ring depth and fixed field widths
    localparam int DEPTH_DEF   = 32;
    localparam int TASK_W      = 32;
    localparam int MASK_W      = 32;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int QDEPTH_W    = 6;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SIGNAL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BROADCAST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WOKEN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

    // Read address sources
    localparam logic [1:0] RD_RP        = 2'd0;
    localparam logic [1:0] RD_RP_NEXT   = 2'd1;
    localparam logic [1:0] RD_ADDR_NEXT = 2'd2;
    localparam logic [1:0] RD_ADDR_NXT2 = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic                latch;
        logic                enq;
        logic                pop;
        logic                rm;
        logic                scan_init;
        logic                scan_step;
        logic                shift_wr;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                emit;
        logic                emit_woken;
        logic                emit_last;
        logic [STATUS_W-1:0] emit_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             full;
        logic             match;
        logic             cnt_more;
        logic             shift_more;
        logic             occ_one;
        logic             out_free;
    } t_dp_sts;

endpackage

### src/wq_ctrl.sv
// Sequencer for the wait queue: dispatch, pop, search and compaction steps.
module wq_ctrl import wq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_POP      = 3'd2;
    localparam logic [2:0] S_SEARCH   = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_REMOVED  = 3'd5;
    localparam logic [2:0] S_NOTFOUND = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_ENQUEUE: begin
                        if (i_sts.out_free) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.emit_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.emit_status = ST_QUEUED;
                                o_cmd.enq         = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_SIGNAL, CMD_BROADCAST: begin
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_last   = 1'b1;
                                o_cmd.emit_status = ST_EMPTY;
                                n_state           = S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_RP;
                            n_state      = S_POP;
                        end
                    end
                    CMD_REMOVE: begin
                        if (i_sts.empty) begin
                            n_state = S_NOTFOUND;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            o_cmd.rd_en     = 1'b1;
                            o_cmd.rd_sel    = RD_RP;
                            n_state         = S_SEARCH;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_POP: begin
                // Read data holds the oldest waiter; next read overlaps the transfer
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_woken  = 1'b1;
                    o_cmd.emit_status = ST_WOKEN;
                    o_cmd.pop         = 1'b1;
                    if (i_sts.cmd == CMD_SIGNAL || i_sts.occ_one) begin
                        o_cmd.emit_last = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_RP_NEXT;
                    end
                end
            end
            S_SEARCH: begin
                if (i_sts.match) begin
                    if (i_sts.cnt_more) begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_ADDR_NEXT;
                        n_state      = S_SHIFT;
                    end else begin
                        n_state = S_REMOVED;
                    end
                end else if (i_sts.cnt_more) begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = RD_ADDR_NEXT;
                end else begin
                    n_state = S_NOTFOUND;
                end
            end
            S_SHIFT: begin
                // Move the later entry down one slot, fetch the one after it
                o_cmd.shift_wr  = 1'b1;
                o_cmd.scan_step = 1'b1;
                if (i_sts.shift_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ADDR_NXT2;
                end else begin
                    n_state = S_REMOVED;
                end
            end
            S_REMOVED: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_REMOVED;
                    o_cmd.rm          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_NOTFOUND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_last   = 1'b1;
                    o_cmd.emit_status = ST_NOT_FOUND;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/wq_datapath.sv
// Waiter ring memory, pointers, scan counter and result register.
module wq_datapath import wq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [TASK_W-1:0]   i_waiter_task,
    input  logic [MASK_W-1:0]   i_waiter_mask,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TASK_W-1:0]   o_woken_task,
    output logic [MASK_W-1:0]   o_woken_mask,
    output logic [QDEPTH_W-1:0] o_queue_depth,
    output logic                o_last
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int EW = TASK_W + MASK_W;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] prev_idx(input logic [PW-1:0] p);
        return (p == '0) ? LAST_IDX : p - 1'b1;
    endfunction

    logic [EW-1:0]       r_mem [DEPTH];
    logic [EW-1:0]       r_rdata;
    logic [CMD_W-1:0]    r_cmd;
    logic [TASK_W-1:0]   r_task;
    logic [MASK_W-1:0]   r_mask;
    logic [PW-1:0]       r_wp;
    logic [PW-1:0]       r_rp;
    logic [OW-1:0]       r_occ;
    logic [PW-1:0]       r_addr;
    logic [OW-1:0]       r_cnt;
    logic [OW-1:0]       n_occ;
    logic [PW-1:0]       rd_addr;
    logic [PW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                wr_en;
    logic [OW:0]         cnt_p1;
    logic [OW:0]         cnt_p2;
    logic [31:0]         occ_wide;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [TASK_W-1:0]   r_wtask;
    logic [MASK_W-1:0]   r_wmask;
    logic [QDEPTH_W-1:0] r_qdepth;
    logic                r_last;
    logic                out_free;

    // Latched command fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd  <= i_command;
            r_task <= i_waiter_task;
            r_mask <= i_waiter_mask;
        end
    end

    // Occupancy next value
    always_comb begin
        n_occ = r_occ;
        if (i_cmd.enq) begin
            n_occ = r_occ + 1'b1;
        end else if (i_cmd.pop || i_cmd.rm) begin
            n_occ = r_occ - 1'b1;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
            if (i_cmd.enq) begin
                r_wp <= next_idx(r_wp);
            end else if (i_cmd.rm) begin
                r_wp <= prev_idx(r_wp);
            end
            if (i_cmd.pop) begin
                r_rp <= next_idx(r_rp);
            end
        end
    end

    // Scan position and count for remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_addr <= r_rp;
            r_cnt  <= '0;
        end else if (i_cmd.scan_step) begin
            r_addr <= next_idx(r_addr);
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // Memory port selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_RP:        rd_addr = r_rp;
            RD_RP_NEXT:   rd_addr = next_idx(r_rp);
            RD_ADDR_NEXT: rd_addr = next_idx(r_addr);
            RD_ADDR_NXT2: rd_addr = next_idx(next_idx(r_addr));
            default:      rd_addr = r_rp;
        endcase
        wr_en   = i_cmd.enq || i_cmd.shift_wr;
        wr_addr = i_cmd.shift_wr ? r_addr : r_wp;
        wr_data = i_cmd.shift_wr ? r_rdata : {r_task, r_mask};
    end

    // Ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Result register
    assign out_free = !r_out_valid || !i_out_stall;
    assign occ_wide = 32'(n_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.emit_status;
            r_wtask  <= i_cmd.emit_woken ? r_rdata[EW-1:MASK_W] : '0;
            r_wmask  <= i_cmd.emit_woken ? r_rdata[MASK_W-1:0] : '0;
            r_qdepth <= occ_wide[QDEPTH_W-1:0];
            r_last   <= i_cmd.emit_last;
        end
    end

    // Status toward the controller
    assign cnt_p1 = {1'b0, r_cnt} + 1'b1;
    assign cnt_p2 = {1'b0, r_cnt} + 2'd2;

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_cmd;
        o_sts.empty      = (r_occ == '0);
        o_sts.full       = (r_occ >= FULL_OCC);
        o_sts.match      = (r_rdata == {r_task, r_mask});
        o_sts.cnt_more   = (cnt_p1 < {1'b0, r_occ});
        o_sts.shift_more = (cnt_p2 < {1'b0, r_occ});
        o_sts.occ_one    = (r_occ == OW'(1));
        o_sts.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_woken_task  = r_wtask;
    assign o_woken_mask  = r_wmask;
    assign o_queue_depth = r_qdepth;
    assign o_last        = r_last;

endmodule

### src/fifo_wait_queue_with_removal.sv
// Top level of the FIFO wait queue with keyed removal.
//
//  channel  direction  handshake                   payload
//  input    in         i_in_valid / o_in_stall     i_command, i_waiter_task, i_waiter_mask
//  output   out        o_out_valid / i_out_stall   o_status, o_woken_task, o_woken_mask,
//                                                  o_queue_depth, o_last
//
// Items are taken one at a time; a remove walks the ring one entry per cycle
// through the ring memory's single read port.
// A result sits in the output register while the next item is taken; a stalled
// output holds the sequencer until the register frees.
// Reset (synchronous, active low) clears pointers, occupancy, the output valid flag
// and the sequencer; ring entries are not cleared and are read only once written.
module fifo_wait_queue_with_removal import wq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [TASK_W-1:0]   i_waiter_task,
    input  logic [MASK_W-1:0]   i_waiter_mask,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TASK_W-1:0]   o_woken_task,
    output logic [MASK_W-1:0]   o_woken_mask,
    output logic [QDEPTH_W-1:0] o_queue_depth,
    output logic                o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    wq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Ring and result datapath
    wq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_command     (i_command),
        .i_waiter_task (i_waiter_task),
        .i_waiter_mask (i_waiter_mask),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_woken_task  (o_woken_task),
        .o_woken_mask  (o_woken_mask),
        .o_queue_depth (o_queue_depth),
        .o_last        (o_last)
    );

endmodule
